>>> design/mwpd_pkg.sv
// Shared types and constants for the MIME encoded-word payload decoder.
`timescale 1ns / 1ps

package mwpd_pkg;

    localparam int DEFAULT_COUNT_LIMIT = 2047;

    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 11;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [MODE_W-1:0] MODE_QP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_B64 = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0] DELIMITER_RESET = 8'd63;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] char_in;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] delimiter;
        logic              allow_high;
    } cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  data;
        logic               data_valid;
        logic               word_end;
        logic               failed;
        logic [COUNT_W-1:0] byte_count;
    } res_t;

endpackage

>>> design/mwpd_in_stage.sv
// Input register that holds one accepted character or flush transaction.
`timescale 1ns / 1ps

module mwpd_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mwpd_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output mwpd_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    mwpd_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> design/mwpd_core.sv
// Decoding state and next-state logic for quoted-printable and base64 words.
`timescale 1ns / 1ps

module mwpd_core #(
    parameter int COUNT_LIMIT = mwpd_pkg::DEFAULT_COUNT_LIMIT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  mwpd_pkg::item_t item,
    input  mwpd_pkg::cfg_t  cfg,
    output logic            has_result,
    output mwpd_pkg::res_t  res
);

    localparam int CW = $clog2(COUNT_LIMIT + 1);

    localparam logic [1:0] QP_IDLE  = 2'd0;
    localparam logic [1:0] QP_EQUAL = 2'd1;
    localparam logic [1:0] QP_HEX   = 2'd2;

    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_US    = 8'h5F;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        return v;
    endfunction

    function automatic logic [6:0] b64_rank(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd64;
        if (c >= 8'h41 && c <= 8'h5A) r = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) r = 7'(c - 8'h47);
        else if (c >= 8'h30 && c <= 8'h39) r = 7'(c + 8'h04);
        else if (c == 8'h2B) r = 7'd62;
        else if (c == 8'h2F) r = 7'd63;
        return r;
    endfunction

    logic [1:0]    qp_phase_reg, qp_phase_next;
    logic [3:0]    nibble_reg, nibble_next;
    logic [5:0]    pattern_reg, pattern_next;
    logic [2:0]    bits_reg, bits_next;
    logic          disc_reg, disc_next;
    logic [CW-1:0] count_reg, count_next;

    logic [CW-1:0] count_inc;
    logic [4:0]    hex;
    logic [6:0]    rank;
    logic [11:0]   pattern_shift;
    logic [3:0]    bit_sum;
    logic [7:0]    put_data;
    logic          put;
    logic          word_done;
    logic          fail;
    logic [7:0]    hex_byte;
    logic [7:0]    b64_byte;

    assign count_inc = (count_reg < CW'(COUNT_LIMIT)) ? count_reg + 1'b1 : count_reg;
    assign hex       = hex_value(item.char_in);
    assign rank      = b64_rank(item.char_in);
    assign pattern_shift = {pattern_reg, rank[5:0]};
    assign bit_sum   = {1'b0, bits_reg} + 4'd6;
    assign hex_byte  = {nibble_reg, hex[3:0]};
    assign b64_byte  = 8'(pattern_shift >> bit_sum[2:0]);
    assign fail      = disc_reg || (cfg.mode > mwpd_pkg::MODE_B64)
                       || (cfg.mode == mwpd_pkg::MODE_QP && qp_phase_reg != QP_IDLE);

    always_comb begin
        qp_phase_next = qp_phase_reg;
        nibble_next   = nibble_reg;
        pattern_next  = pattern_reg;
        bits_next     = bits_reg;
        disc_next     = disc_reg;
        count_next    = count_reg;
        put           = 1'b0;
        put_data      = item.char_in;
        word_done     = 1'b0;
        if (item.kind) begin
            pattern_next = '0;
            bits_next    = '0;
        end else if (item.char_in == cfg.delimiter) begin
            word_done     = 1'b1;
            count_next    = '0;
            qp_phase_next = QP_IDLE;
            disc_next     = 1'b0;
        end else if (!disc_reg) begin
            unique case (cfg.mode)
                mwpd_pkg::MODE_QP: begin
                    if (qp_phase_reg == QP_IDLE) begin
                        if (item.char_in == CHAR_EQ) begin
                            qp_phase_next = QP_EQUAL;
                        end else begin
                            put = 1'b1;
                            if (cfg.delimiter != 8'd0 && item.char_in == CHAR_US) begin
                                put_data = CHAR_SPACE;
                            end
                        end
                    end else if (qp_phase_reg == QP_EQUAL && item.char_in == CHAR_NL) begin
                        qp_phase_next = QP_IDLE;
                    end else if (hex[4]) begin
                        disc_next     = 1'b1;
                        qp_phase_next = QP_IDLE;
                    end else if (qp_phase_reg == QP_EQUAL) begin
                        nibble_next   = hex[3:0];
                        qp_phase_next = QP_HEX;
                    end else begin
                        qp_phase_next = QP_IDLE;
                        put           = 1'b1;
                        put_data      = (hex_byte[7] && !cfg.allow_high) ? CHAR_QMARK
                                                                         : hex_byte;
                    end
                end
                mwpd_pkg::MODE_B64: begin
                    if (!rank[6]) begin
                        pattern_next = rank[5:0];
                        bits_next    = bit_sum[2:0];
                        if (bit_sum[3]) begin
                            put      = 1'b1;
                            put_data = (b64_byte[7] && !cfg.allow_high) ? CHAR_QMARK
                                                                        : b64_byte;
                        end
                    end
                end
                default: begin
                    disc_next = 1'b1;
                end
            endcase
            if (put) begin
                count_next = count_inc;
            end
        end
    end

    always_comb begin
        res            = '0;
        res.word_end   = word_done;
        res.failed     = word_done && fail;
        res.data_valid = put;
        res.data       = put ? put_data : 8'd0;
        res.byte_count = put ? mwpd_pkg::COUNT_W'(count_inc)
                             : mwpd_pkg::COUNT_W'(count_reg);
    end

    assign has_result = put || word_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qp_phase_reg <= QP_IDLE;
            nibble_reg   <= '0;
            pattern_reg  <= '0;
            bits_reg     <= '0;
            disc_reg     <= 1'b0;
            count_reg    <= '0;
        end else if (en) begin
            qp_phase_reg <= qp_phase_next;
            nibble_reg   <= nibble_next;
            pattern_reg  <= pattern_next;
            bits_reg     <= bits_next;
            disc_reg     <= disc_next;
            count_reg    <= count_next;
        end
    end

    a_bits_even: assert property (@(posedge aclk) disable iff (!aresetn)
        !bits_reg[0] && bits_reg <= 3'd6)
        else $error("base64 bit count left the set of reachable values");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        en && word_done |=> count_reg == '0 && !disc_reg && qp_phase_reg == QP_IDLE)
        else $error("word state not cleared after the end of a word");

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        !(put && word_done))
        else $error("result both a byte and an end of word");

    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        qp_phase_reg != 2'd3)
        else $error("quoted-printable phase reached an unused code");

    a_disc_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        disc_reg && !word_done |-> !put)
        else $error("byte produced while dropping a failed word");

endmodule

>>> design/mwpd_out_stage.sv
// Output register that holds one result transaction until it is taken.
`timescale 1ns / 1ps

module mwpd_out_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  mwpd_pkg::res_t res,
    output logic           busy,
    output logic           m_tvalid,
    input  logic           m_tready,
    output mwpd_pkg::res_t m_res
);

    logic           valid_reg;
    logic           valid_next;
    mwpd_pkg::res_t res_reg;

    assign busy       = valid_reg && !m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

>>> design/mime_word_payload_decoder_top.sv
// Top level of the MIME encoded-word payload decoder with its configuration registers.
`timescale 1ns / 1ps

// The decoder takes one character or flush transaction in every clock cycle unless a
// result waits behind a stalled output, and gives at most one result for each item:
// it waits in the input register, then decode logic loads the output. The output
// register lets a new character enter while a result still waits on m_tready, so
// characters that give no result keep flowing during a stall. There is no start-up
// pass after reset. Configuration writes are taken at once and should be made only
// while no transaction is in flight.

module mime_word_payload_decoder_top #(
    parameter int COUNT_LIMIT = mwpd_pkg::DEFAULT_COUNT_LIMIT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data, [18:8] byte_count, [23:19] zero
    output logic [1:0]  m_tuser,   // [0] data_valid, [1] failed
    output logic        m_tlast,   // word_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [mwpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mwpd_pkg::CFG_DAT_W-1:0] cfg_data
);

    mwpd_pkg::cfg_t  cfg_reg;
    mwpd_pkg::item_t s_item;
    mwpd_pkg::item_t item;
    mwpd_pkg::res_t  res;
    mwpd_pkg::res_t  m_res;
    logic            item_valid;
    logic            has_result;
    logic            out_busy;
    logic            advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode       <= mwpd_pkg::MODE_QP;
            cfg_reg.delimiter  <= mwpd_pkg::DELIMITER_RESET;
            cfg_reg.allow_high <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mwpd_pkg::CFG_MODE:       cfg_reg.mode       <= cfg_data[mwpd_pkg::MODE_W-1:0];
                mwpd_pkg::CFG_DELIMITER:  cfg_reg.delimiter  <= cfg_data;
                mwpd_pkg::CFG_ALLOW_HIGH: cfg_reg.allow_high <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_item.kind    = s_tuser[0];
    assign s_item.char_in = s_tdata;

    assign advance = item_valid && (!has_result || !out_busy);

    mwpd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mwpd_core #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .item       (item),
        .cfg        (cfg_reg),
        .has_result (has_result),
        .res        (res)
    );

    mwpd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && has_result),
        .res      (res),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {5'd0, m_res.byte_count, m_res.data};
    assign m_tuser = {m_res.failed, m_res.data_valid};
    assign m_tlast = m_res.word_end;

endmodule

>>> verif/mime_word_payload_decoder_top_tb.sv
// Self-checking testbench for the MIME encoded-word payload decoder top level.
`timescale 1ns / 1ps

module mime_word_payload_decoder_top_tb;

    localparam int COUNT_LIMIT   = mwpd_pkg::DEFAULT_COUNT_LIMIT;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int TOTAL_ITEMS   = 1120;

    localparam logic [mwpd_pkg::MODE_W-1:0] MODE_UNKNOWN  = 2'd2;
    localparam logic [mwpd_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [7:0] CH_EQ         = 8'h3d;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_NEWLINE    = 8'h0a;
    localparam logic [7:0] CH_QMARK      = 8'h3f;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    localparam logic [1:0] QP_IDLE      = 2'd0;
    localparam logic [1:0] QP_AFTER_EQ  = 2'd1;
    localparam logic [1:0] QP_AFTER_HEX = 2'd2;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic [0:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [23:0]                    m_tdata;
    logic [1:0]                     m_tuser;
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mwpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mwpd_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

    // Register copies and decoder state of the predictor.
    logic [mwpd_pkg::MODE_W-1:0] mode_reg       = mwpd_pkg::MODE_QP;
    logic [7:0]                  delim_reg      = mwpd_pkg::DELIMITER_RESET;
    logic                        allow_high_reg = 1'b0;
    logic [1:0]                  qp_state       = QP_IDLE;
    logic [3:0]                  hex_hi         = '0;
    logic [15:0]                 b64_acc        = '0;
    logic [4:0]                  b64_cnt        = '0;
    logic                        drop_word      = 1'b0;
    logic [10:0]                 word_count     = '0;

    mwpd_pkg::item_t char_q[$];
    mwpd_pkg::res_t  decoded_q[$];
    mwpd_pkg::item_t on_bus;
    int    queued_cnt    = 0;
    int    accepted_cnt  = 0;
    int    mismatches    = 0;
    int    src_gap_max   = 8;
    int    snk_gap_max   = 8;
    int    src_wait      = 0;
    int    sink_wait     = 0;
    int    sink_hold     = 0;
    int    sink_hold_req = 0;

    mime_word_payload_decoder_top #(
        .COUNT_LIMIT(COUNT_LIMIT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        return 5'd16;
    endfunction

    function automatic logic [6:0] b64_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 7'(c - "A");
        if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
        if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
        if (c == "+") return 7'd62;
        if (c == "/") return 7'd63;
        return 7'd64;
    endfunction

    function automatic logic [7:0] limit_high(input logic [7:0] b);
        return (b[7] && !allow_high_reg) ? CH_QMARK : b;
    endfunction

    function automatic mwpd_pkg::res_t put_decoded(input logic [7:0] b);
        mwpd_pkg::res_t r;
        if (word_count < COUNT_LIMIT) word_count++;
        r = '0;
        r.data       = b;
        r.data_valid = 1'b1;
        r.byte_count = word_count;
        return r;
    endfunction

    function automatic bit decode_char(input mwpd_pkg::item_t it, output mwpd_pkg::res_t r);
        logic [7:0] c;
        logic [4:0] hv;
        logic [6:0] rank;
        c = it.char_in;
        r = '0;
        if (it.kind == KIND_FLUSH) begin
            b64_acc = '0;
            b64_cnt = '0;
            return 1'b0;
        end
        if (c == delim_reg) begin
            r.word_end   = 1'b1;
            r.failed     = drop_word || (mode_reg > mwpd_pkg::MODE_B64) ||
                           (mode_reg == mwpd_pkg::MODE_QP && qp_state != QP_IDLE);
            r.byte_count = word_count;
            word_count   = '0;
            qp_state     = QP_IDLE;
            drop_word    = 1'b0;
            return 1'b1;
        end
        if (drop_word) return 1'b0;
        case (mode_reg)
            mwpd_pkg::MODE_QP: begin
                if (qp_state == QP_IDLE) begin
                    if (c == CH_EQ) begin
                        qp_state = QP_AFTER_EQ;
                        return 1'b0;
                    end
                    if (delim_reg != 8'h00 && c == CH_UNDERSCORE) begin
                        r = put_decoded(CH_SPACE);
                        return 1'b1;
                    end
                    r = put_decoded(c);
                    return 1'b1;
                end
                if (qp_state == QP_AFTER_EQ && c == CH_NEWLINE) begin
                    qp_state = QP_IDLE;
                    return 1'b0;
                end
                hv = hex_digit(c);
                if (hv[4]) begin
                    drop_word = 1'b1;
                    qp_state  = QP_IDLE;
                    return 1'b0;
                end
                if (qp_state == QP_AFTER_EQ) begin
                    hex_hi   = hv[3:0];
                    qp_state = QP_AFTER_HEX;
                    return 1'b0;
                end
                qp_state = QP_IDLE;
                r = put_decoded(limit_high({hex_hi, hv[3:0]}));
                return 1'b1;
            end
            mwpd_pkg::MODE_B64: begin
                rank = b64_value(c);
                if (rank[6]) return 1'b0;
                b64_acc = {b64_acc[9:0], rank[5:0]};
                b64_cnt = b64_cnt + 5'd6;
                if (b64_cnt >= 5'd8) begin
                    r = put_decoded(limit_high(8'(b64_acc >> (b64_cnt - 5'd8))));
                    b64_cnt = b64_cnt - 5'd8;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                drop_word = 1'b1;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge aclk) begin : char_driver
        mwpd_pkg::res_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (decode_char(on_bus, r)) decoded_q.push_back(r);
                accepted_cnt++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    on_bus = char_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= on_bus.char_in;
                    s_tuser  <= on_bus.kind;
                    src_wait = $urandom_range(src_gap_max, 0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        mwpd_pkg::res_t want;
        logic go;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual data %0d count %0d",
                             $time, m_tdata[7:0], m_tdata[18:8]);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("data", want.data, m_tdata[7:0]);
                    check_field("byte_count", want.byte_count, m_tdata[18:8]);
                    check_field("data_valid", want.data_valid, m_tuser[0]);
                    check_field("failed", want.failed, m_tuser[1]);
                    check_field("word_end", want.word_end, m_tlast);
                end
                sink_wait = $urandom_range(snk_gap_max, 0);
            end
            if (sink_hold_req > 0) begin
                sink_hold     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                go = 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                go = 1'b0;
            end else begin
                go = 1'b1;
            end
            m_tready <= go;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("mime_word_payload_decoder_top regression: fail");
        $finish;
    end

    task automatic push_item(input logic kind, input logic [7:0] c);
        mwpd_pkg::item_t it;
        it.kind    = kind;
        it.char_in = c;
        char_q.push_back(it);
        queued_cnt++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_item(KIND_CHAR, s[i]);
    endtask

    task automatic set_registers(input logic [mwpd_pkg::MODE_W-1:0] m, input logic [7:0] d,
                                 input logic a);
        logic [mwpd_pkg::CFG_IDX_W-1:0] idx [3];
        logic [mwpd_pkg::CFG_DAT_W-1:0] val [3];
        idx = '{mwpd_pkg::CFG_MODE, mwpd_pkg::CFG_DELIMITER, mwpd_pkg::CFG_ALLOW_HIGH};
        val = '{{6'd0, m}, d, {7'd0, a}};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        end
        cfg_valid <= 1'b0;
        mode_reg       = m;
        delim_reg      = d;
        allow_high_reg = a;
    endtask

    task automatic drain();
        while (accepted_cnt != queued_cnt || decoded_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(15, 0);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(1, 0) ? "a" : "A") + v - 10);
    endfunction

    function automatic logic [7:0] b64_char();
        int v;
        v = $urandom_range(63, 0);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    task automatic qp_word();
        int pieces;
        int sel;
        pieces = $urandom_range(12, 0);
        for (int p = 0; p < pieces; p++) begin
            sel = $urandom_range(99, 0);
            if (sel < 45) begin
                push_item(KIND_CHAR, 8'($urandom_range(255, 0)));
            end else if (sel < 70) begin
                push_item(KIND_CHAR, CH_EQ);
                push_item(KIND_CHAR, hex_char());
                push_item(KIND_CHAR, hex_char());
            end else if (sel < 78) begin
                push_item(KIND_CHAR, CH_EQ);
                push_item(KIND_CHAR, CH_NEWLINE);
            end else if (sel < 88) begin
                push_item(KIND_CHAR, CH_UNDERSCORE);
            end else if (sel < 94) begin
                push_item(KIND_CHAR, CH_EQ);
                push_item(KIND_CHAR, 8'($urandom_range(255, 0)));
            end else if (sel < 97) begin
                push_item(KIND_CHAR, CH_EQ);
                break;
            end else begin
                push_item(KIND_CHAR, CH_EQ);
                push_item(KIND_CHAR, hex_char());
                break;
            end
        end
        if ($urandom_range(9, 0) != 0) push_item(KIND_CHAR, delim_reg);
    endtask

    task automatic b64_word();
        int n;
        int sel;
        n = $urandom_range(16, 0);
        repeat (n) begin
            sel = $urandom_range(99, 0);
            if (sel < 85)      push_item(KIND_CHAR, b64_char());
            else if (sel < 93) push_item(KIND_CHAR, 8'($urandom_range(255, 0)));
            else if (sel < 96) push_item(KIND_FLUSH, 8'($urandom_range(255, 0)));
            else               push_item(KIND_CHAR, CH_EQ);
        end
        if ($urandom_range(9, 0) != 0) push_item(KIND_CHAR, delim_reg);
    endtask

    task automatic noise_word();
        repeat ($urandom_range(12, 0))
            push_item(($urandom_range(7, 0) == 0) ? KIND_FLUSH : KIND_CHAR,
                      8'($urandom_range(255, 0)));
        if ($urandom_range(3, 0) != 0) push_item(KIND_CHAR, delim_reg);
    endtask

    initial begin : stimulus
        int                          pick;
        logic [mwpd_pkg::MODE_W-1:0] new_mode;
        logic [7:0]                  new_delim;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Quoted-printable escapes, soft break, literals, and the ways a quoted-printable word fails.
        set_registers(mwpd_pkg::MODE_QP, mwpd_pkg::DELIMITER_RESET, 1'b0);
        push_text("=4a=C3=\n_A");
        push_item(KIND_CHAR, 8'hff);
        push_item(KIND_CHAR, 8'h00);
        push_text("=fF?=Gx?=?=4?");
        push_item(KIND_FLUSH, 8'h00);
        drain();

        // Base64 with skipped characters, a flush mid-group, and a zero delimiter.
        set_registers(mwpd_pkg::MODE_B64, 8'h00, 1'b1);
        push_text("/w-_Q");
        push_item(KIND_FLUSH, 8'hff);
        push_text("QUJD");
        push_item(KIND_CHAR, 8'h00);
        drain();

        set_registers(MODE_UNKNOWN, 8'hff, 1'b0);
        push_text("ab");
        push_item(KIND_CHAR, 8'hff);
        drain();

        set_registers(mwpd_pkg::MODE_QP, 8'h00, 1'b1);
        push_text("_=E9");
        push_item(KIND_CHAR, 8'h00);
        drain();

        // Long receiver stall while the sender keeps offering.
        src_gap_max   = 0;
        sink_hold_req = HOLD_CYCLES;
        set_registers(mwpd_pkg::MODE_QP, mwpd_pkg::DELIMITER_RESET, 1'b0);
        repeat (40) push_item(KIND_CHAR, 8'($urandom_range(255, 0)));
        push_item(KIND_CHAR, delim_reg);
        drain();

        while (queued_cnt < TOTAL_ITEMS) begin
            pick = $urandom_range(9, 0);
            new_mode = (pick < 4) ? mwpd_pkg::MODE_QP : (pick < 8) ? mwpd_pkg::MODE_B64 :
                       (pick < 9) ? MODE_UNKNOWN : MODE_RESERVED;
            case ($urandom_range(5, 0))
                0:       new_delim = mwpd_pkg::DELIMITER_RESET;
                1:       new_delim = 8'h00;
                2:       new_delim = 8'hff;
                3:       new_delim = CH_EQ;
                4:       new_delim = CH_UNDERSCORE;
                default: new_delim = 8'($urandom_range(255, 0));
            endcase
            set_registers(new_mode, new_delim, 1'($urandom_range(1, 0)));
            src_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 8;
            snk_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 8;
            repeat ($urandom_range(8, 2)) begin
                if ($urandom_range(9, 0) == 0)           noise_word();
                else if (mode_reg == mwpd_pkg::MODE_QP)  qp_word();
                else if (mode_reg == mwpd_pkg::MODE_B64) b64_word();
                else                                     noise_word();
            end
            drain();
        end

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("mime_word_payload_decoder_top regression: pass");
        end else begin
            $display("mime_word_payload_decoder_top regression: fail");
        end
        $finish;
    end

endmodule
